@@ hw/rtl/small_integer_primitive_alu_defines.svh @@
// Assertion macros used by the small-integer ALU RTL.
`ifndef SMALL_INTEGER_PRIMITIVE_ALU_DEFINES_SVH
`define SMALL_INTEGER_PRIMITIVE_ALU_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define SIA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequence is checked in the cycle after the antecedent, also during reset.
`define SIA_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/sia_pkg.sv @@
// Types, operation codes and helpers for the small-integer ALU.
package sia_pkg;

    localparam logic [3:0] FUNC_ADD     = 4'd0;
    localparam logic [3:0] FUNC_SUB     = 4'd1;
    localparam logic [3:0] FUNC_MUL     = 4'd2;
    localparam logic [3:0] FUNC_DIV     = 4'd3;
    localparam logic [3:0] FUNC_MOD     = 4'd4;
    localparam logic [3:0] FUNC_LESS    = 4'd5;
    localparam logic [3:0] FUNC_LESS_EQ = 4'd6;
    localparam logic [3:0] FUNC_EQUAL   = 4'd7;
    localparam logic [3:0] FUNC_OR      = 4'd8;
    localparam logic [3:0] FUNC_AND     = 4'd9;
    localparam logic [3:0] FUNC_SHIFT   = 4'd10;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DIVZ  = 2'd1;
    localparam logic [1:0] ST_SHOVF = 2'd2;

    localparam int DIV_BITS = 32;

    typedef struct packed {
        logic [3:0]  func;
        logic [31:0] lhs;
        logic [31:0] rhs;
    } t_req;

    typedef struct packed {
        logic [3:0]  func;
        logic [31:0] res;
        logic [1:0]  st;
        logic        qneg;
        logic        rneg;
        logic [31:0] rem;
        logic [31:0] quo;
        logic [31:0] dvs;
    } t_stage;

    // One restoring step: shift the next dividend bit into the remainder.
    function automatic t_stage div_step(input t_stage s);
        t_stage      o;
        logic [32:0] trial;
        logic [32:0] diff;
        o     = s;
        trial = {s.rem, s.quo[31]};
        diff  = trial - {1'b0, s.dvs};
        if (!diff[32]) begin
            o.rem = diff[31:0];
            o.quo = {s.quo[30:0], 1'b1};
        end else begin
            o.rem = trial[31:0];
            o.quo = {s.quo[30:0], 1'b0};
        end
        return o;
    endfunction

endpackage

@@ hw/rtl/small_integer_primitive_alu.sv @@
// Top level of the pipelined small-integer ALU.
//
//  channel   | dir | fields (low bit up)                        | handshake
//  ----------+-----+--------------------------------------------+----------------------
//  s (input) | in  | tdata: func[3:0] lhs[35:4] rhs[67:36] pad  | i_s_tvalid/o_s_tready
//  m (output)| out | tdata: result[31:0] status[33:32] pad      | o_m_tvalid/i_m_tready
//
// One request enters per cycle while the output is not stalled, and passes 35 register
// stages: input register, operand stage (multiplier, shifter, compares, divider setup),
// 32 one-bit restoring divide stages, output stage. The divider chain sets the
// latency; every operation travels the same depth.
// Reset clears the valid bits only. A stall on the output freezes the whole
// pipe at once, so nothing is lost or repeated.
module small_integer_primitive_alu
    import sia_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,   // func[3:0], lhs[35:4], rhs[67:36], zeros
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // result[31:0], status[33:32], zeros
);

    localparam int NSTG = DIV_BITS + 3;

    logic [NSTG-1:0] r_vld;
    t_req            r_req;
    t_stage          r_stg [0:DIV_BITS];
    logic [31:0]     r_res;
    logic [1:0]      r_st;

    logic            adv;
    t_stage          n_stg0;
    logic [31:0]     n_res;
    logic [31:0]     mul;
    logic [31:0]     shl;
    logic [32:0]     ramt;
    logic [31:0]     shr;

    // Advance the whole pipe when the output slot is empty or being taken.
    assign adv        = !r_vld[NSTG-1] || i_m_tready;
    assign o_s_tready = adv;
    assign o_m_tvalid = r_vld[NSTG-1];
    assign o_m_tdata  = {6'd0, r_st, r_res};

    // Operand stage: everything but the divide is finished here.
    always_comb begin
        mul  = r_req.lhs * r_req.rhs;
        shl  = (r_req.rhs[31:5] != 27'd0) ? 32'd0 : (r_req.lhs << r_req.rhs[4:0]);
        ramt = 33'd0 - {r_req.rhs[31], r_req.rhs};
        if (ramt[32:5] != 28'd0) begin
            shr = {32{r_req.lhs[31]}};
        end else begin
            shr = $unsigned($signed(r_req.lhs) >>> ramt[4:0]);
        end
        n_stg0      = '0;
        n_stg0.func = r_req.func;
        n_stg0.qneg = r_req.lhs[31] ^ r_req.rhs[31];
        n_stg0.rneg = r_req.lhs[31];
        n_stg0.quo  = r_req.lhs[31] ? (32'd0 - r_req.lhs) : r_req.lhs;
        n_stg0.dvs  = r_req.rhs[31] ? (32'd0 - r_req.rhs) : r_req.rhs;
        case (r_req.func)
            FUNC_ADD:     n_stg0.res = r_req.lhs + r_req.rhs;
            FUNC_SUB:     n_stg0.res = r_req.lhs - r_req.rhs;
            FUNC_MUL:     n_stg0.res = mul;
            FUNC_DIV,
            FUNC_MOD: begin
                if (r_req.rhs == 32'd0) begin
                    n_stg0.st = ST_DIVZ;
                end
            end
            FUNC_LESS:    n_stg0.res = {31'd0, $signed(r_req.lhs) < $signed(r_req.rhs)};
            FUNC_LESS_EQ: n_stg0.res = {31'd0, $signed(r_req.lhs) <= $signed(r_req.rhs)};
            FUNC_EQUAL:   n_stg0.res = {31'd0, r_req.lhs == r_req.rhs};
            FUNC_OR:      n_stg0.res = r_req.lhs | r_req.rhs;
            FUNC_AND:     n_stg0.res = r_req.lhs & r_req.rhs;
            FUNC_SHIFT: begin
                if (r_req.rhs[31]) begin
                    n_stg0.res = shr;
                end else if ($signed(r_req.lhs) > $signed(shl)) begin
                    n_stg0.st = ST_SHOVF;
                end else begin
                    n_stg0.res = shl;
                end
            end
            default:      n_stg0.res = 32'd0;
        endcase
    end

    // Output stage: apply signs to quotient and remainder.
    always_comb begin
        n_res = r_stg[DIV_BITS].res;
        if (r_stg[DIV_BITS].st == ST_OK) begin
            if (r_stg[DIV_BITS].func == FUNC_DIV) begin
                n_res = r_stg[DIV_BITS].qneg ? (32'd0 - r_stg[DIV_BITS].quo)
                                             : r_stg[DIV_BITS].quo;
            end else if (r_stg[DIV_BITS].func == FUNC_MOD) begin
                n_res = r_stg[DIV_BITS].rneg ? (32'd0 - r_stg[DIV_BITS].rem)
                                             : r_stg[DIV_BITS].rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_s_tvalid};
        end
    end

    // Payload: hold on stall, advance otherwise.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_req.func <= i_s_tdata[3:0];
            r_req.lhs  <= i_s_tdata[35:4];
            r_req.rhs  <= i_s_tdata[67:36];
            r_stg[0]   <= n_stg0;
            for (int k = 1; k <= DIV_BITS; k++) begin
                r_stg[k] <= div_step(r_stg[k-1]);
            end
            r_res <= n_res;
            r_st  <= r_stg[DIV_BITS].st;
        end
    end

`include "small_integer_primitive_alu_defines.svh"

    `SIA_ASSERT_IMP(a_fault_zero, i_clk, i_rst_n, o_m_tvalid && r_st != ST_OK, r_res == 32'd0)
    `SIA_ASSERT_IMP(a_st_range, i_clk, i_rst_n, o_m_tvalid, r_st != 2'd3)
    `SIA_ASSERT_NEXT(a_rst_empty, i_clk, !i_rst_n, !o_m_tvalid)
    `SIA_ASSERT_IMP(a_hold_out, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, !o_s_tready)

endmodule

@@ tb/sv/small_integer_primitive_alu_tb.sv @@
// Self-checking testbench for the small-integer primitive ALU.
module small_integer_primitive_alu_tb;
    import sia_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM   = 400;
    localparam int IDLE_MAX   = 13;
    localparam int DRAIN_WAIT = 60;
    localparam int STALL_LIM  = 2000;   // cycles with no request moving on either side

    typedef struct packed {
        logic [3:0]  func;
        logic [31:0] lhs;
        logic [31:0] rhs;
        logic        known;   // 1 when the typed-in result below holds
        logic [31:0] res;
        logic [1:0]  st;
    } t_vec;

    typedef struct packed {
        logic [31:0] res;
        logic [1:0]  st;
    } t_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [71:0] i_s_tdata;     // func[3:0], lhs[35:4], rhs[67:36], zeros
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [39:0] o_m_tdata;     // result[31:0], status[33:32], zeros

    t_out pending_results[$];
    int   n_fail;
    int   n_sent;
    int   n_got;
    int   idle_cycles;

    small_integer_primitive_alu dut (.*);

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Arithmetic right shift with sign fill past 31.
    function automatic logic [31:0] shift_right_arith(logic [31:0] v, logic [32:0] n);
        logic signed [31:0] sv;
        sv = v;
        if (n >= 33'd32) return {32{v[31]}};
        return sv >>> n[4:0];
    endfunction

    // Compute what the ALU returns for one request.
    function automatic t_out alu_predict(logic [3:0] func, logic [31:0] lhs, logic [31:0] rhs);
        t_out               o;
        logic signed [31:0] sa;
        logic signed [31:0] sb;
        logic [31:0]        sh;
        logic signed [31:0] shs;
        logic [32:0]        mag;
        sa = lhs;
        sb = rhs;
        o  = '0;
        case (func)
            FUNC_ADD: o.res = lhs + rhs;
            FUNC_SUB: o.res = lhs - rhs;
            FUNC_MUL: o.res = lhs * rhs;
            FUNC_DIV, FUNC_MOD: begin
                if (rhs == 32'd0) begin
                    o.st = ST_DIVZ;
                end else if (lhs == 32'h8000_0000 && rhs == 32'hFFFF_FFFF) begin
                    // most negative over minus one: quotient wraps, remainder is zero
                    o.res = (func == FUNC_DIV) ? 32'h8000_0000 : 32'd0;
                end else begin
                    o.res = (func == FUNC_DIV) ? sa / sb : sa % sb;
                end
            end
            FUNC_LESS:    o.res = {31'd0, sa < sb};
            FUNC_LESS_EQ: o.res = {31'd0, sa <= sb};
            FUNC_EQUAL:   o.res = {31'd0, lhs == rhs};
            FUNC_OR:      o.res = lhs | rhs;
            FUNC_AND:     o.res = lhs & rhs;
            FUNC_SHIFT: begin
                if (sb < 0) begin
                    mag   = 33'd0 - {1'b1, rhs};
                    o.res = shift_right_arith(lhs, mag);
                end else begin
                    sh  = (sb >= 32) ? 32'd0 : lhs << rhs[4:0];
                    shs = sh;
                    if (sa > shs) o.st = ST_SHOVF;
                    else          o.res = sh;
                end
            end
            default: o = '0;
        endcase
        return o;
    endfunction

    // Directed rows; known=1 rows carry the expected result inline.
    t_vec directed_rows[] = '{
        '{FUNC_ADD,     32'h7FFF_FFFF, 32'd1,         1'b1, 32'h8000_0000, ST_OK},
        '{FUNC_SUB,     32'h8000_0000, 32'd1,         1'b1, 32'h7FFF_FFFF, ST_OK},
        '{FUNC_MUL,     32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, ST_OK},
        '{FUNC_MUL,     32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 32'd0, ST_OK},
        '{FUNC_DIV,     32'd5,         32'd0,         1'b1, 32'd0, ST_DIVZ},
        '{FUNC_MOD,     32'h8000_0000, 32'd0,         1'b1, 32'd0, ST_DIVZ},
        '{FUNC_DIV,     32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, ST_OK},
        '{FUNC_MOD,     32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'd0, ST_OK},
        '{FUNC_DIV,     32'hFFFF_FFF9, 32'd2,         1'b1, 32'hFFFF_FFFD, ST_OK},
        '{FUNC_MOD,     32'hFFFF_FFF9, 32'd2,         1'b1, 32'hFFFF_FFFF, ST_OK},
        '{FUNC_LESS,    32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'd1, ST_OK},
        '{FUNC_LESS_EQ, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'd1, ST_OK},
        '{FUNC_EQUAL,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd1, ST_OK},
        '{FUNC_OR,      32'hFFFF_0000, 32'h0000_FFFF, 1'b1, 32'hFFFF_FFFF, ST_OK},
        '{FUNC_AND,     32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'd0, ST_OK},
        '{FUNC_SHIFT,   32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 32'hFFFF_FFFF, ST_OK},
        '{FUNC_SHIFT,   32'h7FFF_FFFF, 32'hFFFF_FFE0, 1'b1, 32'd0, ST_OK},
        '{FUNC_SHIFT,   32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'hC000_0000, ST_OK},
        '{FUNC_SHIFT,   32'd1,         32'd32,        1'b1, 32'd0, ST_SHOVF},
        '{FUNC_SHIFT,   32'hFFFF_FFFF, 32'd40,        1'b1, 32'd0, ST_OK},
        '{FUNC_SHIFT,   32'd1,         32'd31,        1'b1, 32'd0, ST_SHOVF},
        '{FUNC_SHIFT,   32'd1,         32'd30,        1'b1, 32'h4000_0000, ST_OK},
        '{FUNC_SHIFT,   32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'd0, ST_SHOVF},
        '{4'd11,        32'h1234_5678, 32'd7,         1'b1, 32'd0, ST_OK},
        '{4'd15,        32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd0, ST_OK}
    };

    // Operand mix that favors the corners and the interesting shift amounts.
    function automatic logic [31:0] pick_operand(bit for_shift);
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($urandom_range(0, 3)) - 32'd1;
            3: return for_shift ? 32'($urandom_range(0, 40)) - 32'd40
                                : 32'($urandom_range(0, 200)) - 32'd100;
            4: return for_shift ? 32'($urandom_range(0, 40)) : $urandom() >> $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    // Hold a request on the input until the block takes it; drop valid only for a gap.
    task automatic send_request(logic [3:0] func, logic [31:0] lhs, logic [31:0] rhs);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'd0, rhs, lhs, func};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // Record the expected result on the edge where the request is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            pending_results.push_back(alu_predict(i_s_tdata[3:0], i_s_tdata[35:4],
                                                  i_s_tdata[67:36]));
            n_sent++;
        end
    end

    // Compare each result with the oldest expectation.
    always @(posedge i_clk) begin
        t_out exp_out;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            n_got++;
            if (pending_results.size() == 0) begin
                $display("%0t: result %h with nothing expected", $time, o_m_tdata);
                n_fail++;
            end else begin
                exp_out = pending_results.pop_front();
                if (o_m_tdata[31:0] !== exp_out.res) begin
                    $display("%0t: result expected %h got %h", $time, exp_out.res,
                             o_m_tdata[31:0]);
                    n_fail++;
                end
                if (o_m_tdata[33:32] !== exp_out.st) begin
                    $display("%0t: status expected %0d got %0d", $time, exp_out.st,
                             o_m_tdata[33:32]);
                    n_fail++;
                end
            end
        end
    end

    // Stall the output side: per result a random wait, with stall-free stretches.
    initial begin
        int wait_cycles;
        i_m_tready = 1'b0;
        @(posedge i_clk);
        forever begin
            wait_cycles = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, IDLE_MAX);
            if (wait_cycles > 0) begin
                i_m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
        end
    end

    // Watchdog on cycles where nothing moves.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIM) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Main sequence: reset, directed table, random requests, drain.
    initial begin
        logic [3:0] func;
        t_out       typed;
        n_fail      = 0;
        n_sent      = 0;
        n_got       = 0;
        idle_cycles = 0;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Check the typed-in rows against the predictor too, so a wrong row shows.
        foreach (directed_rows[k]) begin
            if (directed_rows[k].known) begin
                typed = alu_predict(directed_rows[k].func, directed_rows[k].lhs,
                                    directed_rows[k].rhs);
                if (typed !== {directed_rows[k].res, directed_rows[k].st}) begin
                    $display("%0t: row %0d expected %h/%0d got %h/%0d", $time, k,
                             directed_rows[k].res, directed_rows[k].st,
                             typed.res, typed.st);
                    n_fail++;
                end
            end
            send_request(directed_rows[k].func, directed_rows[k].lhs, directed_rows[k].rhs);
        end

        for (int k = 0; k < N_RANDOM; k++) begin
            func = $urandom_range(0, 15) < 14 ? 4'($urandom_range(0, 10))
                                              : 4'($urandom_range(11, 15));
            send_request(func, pick_operand(1'b0), pick_operand(func == FUNC_SHIFT));
        end
        i_s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d requests (%0d directed), checked %0d results across all ops,",
                 n_sent, directed_rows.size(), n_got);
        $display("including divide faults, INT_MIN/-1 and shift overflow corners.");
        if (n_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/sia_pkg.sv
hw/rtl/small_integer_primitive_alu.sv
tb/sv/small_integer_primitive_alu_tb.sv
